// File: src/srctr_pkg.sv
// Package with shared types, codes and helpers for the split/reconcile stock counter.
package srctr_pkg;

  // Field widths.
  localparam int VALUE_W    = 32;
  localparam int OP_W       = 3;
  localparam int THREAD_W   = 3;
  localparam int RATE_W     = 10;
  localparam int REPORT_W   = 16;
  localparam int CODE_W     = 2;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_CNT_W  = 2;

  // Steps of the split divide: multiply, quotient, remainder.
  localparam int DIV_STEPS = 3;

  // Default chunk count.
  localparam int DEF_NUM_CHUNKS = 8;

  // Reset value of the split threshold (0.65 as per mille).
  localparam logic [RATE_W-1:0] THRESHOLD_RESET = RATE_W'(650);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB    = 3'd2;
  localparam logic [OP_W-1:0] OP_TRANS  = 3'd3;
  localparam logic [OP_W-1:0] OP_STATUS = 3'd4;

  // Result codes.
  localparam logic [CODE_W-1:0] CODE_OK        = 2'd0;
  localparam logic [CODE_W-1:0] CODE_RETRY     = 2'd1;
  localparam logic [CODE_W-1:0] CODE_NO_STOCK  = 2'd2;
  localparam logic [CODE_W-1:0] CODE_NOT_TAKEN = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL   = 1'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // latch a new request and read its chunk
    logic exec;        // decode and finish a single-step request
    logic div_step;    // one step of the split divide
    logic fill;        // write one chunk during a split
    logic gather;      // read one chunk during a reconcile
    logic gather_done; // fold in the last chunk and join
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_transition;
    logic want_split;
    logic want_recon;
    logic div_last;
    logic idx_last;
  } sts_t;

  // Saturating increment of a status counter.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
    return r;
  endfunction

endpackage

// File: src/split_reconcile_counter_top.sv
// Top level of the split/reconcile stock counter.
// A request is taken when start is high and busy is low; its result appears on the
// result ports for one cycle with done high, and the receiver cannot stall it. Read,
// add, subtract, status fetch, unknown operations and a transition that is not taken
// give their result from a single decode state, and busy stays high until then, so
// requests are taken one at a time. A split divides the value by NUM_CHUNKS with a
// reciprocal multiply, a quotient step and a remainder step, and then writes every
// chunk through the single port of the chunk memory.
// A reconcile reads the chunks one per cycle through the same port. Configuration
// writes take effect at once and are meant for idle periods.
module split_reconcile_counter_top #(
  parameter int NUM_CHUNKS = srctr_pkg::DEF_NUM_CHUNKS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cfg_we,
  input  logic [srctr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srctr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [srctr_pkg::OP_W-1:0]        op,
  input  logic [srctr_pkg::THREAD_W-1:0]    thread,
  input  logic [srctr_pkg::VALUE_W-1:0]     amount,
  input  logic [srctr_pkg::RATE_W-1:0]      abort_rate_permille,
  input  logic [srctr_pkg::REPORT_W-1:0]    waiting_count,
  input  logic [srctr_pkg::REPORT_W-1:0]    no_stock_count,
  output logic                              done,
  output logic [srctr_pkg::VALUE_W-1:0]     read_value,
  output logic [srctr_pkg::CODE_W-1:0]      code,
  output logic                              split_now,
  output logic [srctr_pkg::CNT_W-1:0]       aborts_total,
  output logic [srctr_pkg::CNT_W-1:0]       no_stock_total,
  output logic [srctr_pkg::CNT_W-1:0]       commits_total,
  output logic [srctr_pkg::CNT_W-1:0]       waiting_total
);
  import srctr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  srctr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Value path and chunk store.
  srctr_dp #(
    .NUM_CHUNKS (NUM_CHUNKS)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .op                  (op),
    .thread              (thread),
    .amount              (amount),
    .abort_rate_permille (abort_rate_permille),
    .waiting_count       (waiting_count),
    .no_stock_count      (no_stock_count),
    .done                (done),
    .read_value          (read_value),
    .code                (code),
    .split_now           (split_now),
    .aborts_total        (aborts_total),
    .no_stock_total      (no_stock_total),
    .commits_total       (commits_total),
    .waiting_total       (waiting_total)
  );

endmodule

// File: src/srctr_ram.sv
// Generic single-port RAM with registered read data.
module srctr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read first: a write returns the old contents at the same address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: src/srctr_ctrl.sv
// Controller state machine that sequences requests, splits and reconciles.
module srctr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  srctr_pkg::sts_t   sts,
  output srctr_pkg::cmd_t   cmd
);
  import srctr_pkg::*;

  localparam logic [2:0] S_IDLE        = 3'd0;
  localparam logic [2:0] S_DECODE      = 3'd1;
  localparam logic [2:0] S_DIVIDE      = 3'd2;
  localparam logic [2:0] S_FILL        = 3'd3;
  localparam logic [2:0] S_GATHER      = 3'd4;
  localparam logic [2:0] S_GATHER_LAST = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.exec = 1'b1;
        priority if (sts.is_transition && sts.want_recon) begin
          state_next = S_GATHER;
        end else if (sts.is_transition && sts.want_split) begin
          state_next = S_DIVIDE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (sts.idx_last) begin
          state_next = S_IDLE;
        end
      end
      S_GATHER: begin
        cmd.gather = 1'b1;
        if (sts.idx_last) begin
          state_next = S_GATHER_LAST;
        end
      end
      S_GATHER_LAST: begin
        cmd.gather_done = 1'b1;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// File: src/srctr_dp.sv
// Datapath: counter value, chunk store, status counters, divider and result registers.
module srctr_dp #(
  parameter int NUM_CHUNKS = srctr_pkg::DEF_NUM_CHUNKS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  srctr_pkg::cmd_t                   cmd,
  output srctr_pkg::sts_t                   sts,
  input  logic                              cfg_we,
  input  logic [srctr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srctr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [srctr_pkg::OP_W-1:0]        op,
  input  logic [srctr_pkg::THREAD_W-1:0]    thread,
  input  logic [srctr_pkg::VALUE_W-1:0]     amount,
  input  logic [srctr_pkg::RATE_W-1:0]      abort_rate_permille,
  input  logic [srctr_pkg::REPORT_W-1:0]    waiting_count,
  input  logic [srctr_pkg::REPORT_W-1:0]    no_stock_count,
  output logic                              done,
  output logic [srctr_pkg::VALUE_W-1:0]     read_value,
  output logic [srctr_pkg::CODE_W-1:0]      code,
  output logic                              split_now,
  output logic [srctr_pkg::CNT_W-1:0]       aborts_total,
  output logic [srctr_pkg::CNT_W-1:0]       no_stock_total,
  output logic [srctr_pkg::CNT_W-1:0]       commits_total,
  output logic [srctr_pkg::CNT_W-1:0]       waiting_total
);
  import srctr_pkg::*;

  localparam int IDX_W     = $clog2(NUM_CHUNKS);
  localparam int REM_W     = IDX_W + 1;
  localparam int N_THREADS = 2 ** THREAD_W;

  // Reciprocal of NUM_CHUNKS rounded up and scaled by 2^RECIP_SH. With the scale
  // set by the next power of two, the scaled product gives the exact quotient for
  // every 32-bit value. It needs VALUE_W + 1 bits; the top bit is handled by an add.
  localparam int RECIP_SH = VALUE_W + IDX_W;
  localparam logic [2*VALUE_W-1:0] RECIP_WIDE =
    ((64'd1 << RECIP_SH) + 64'(NUM_CHUNKS - 1)) / 64'(NUM_CHUNKS);
  localparam logic [VALUE_W-1:0] RECIP_LO = RECIP_WIDE[VALUE_W-1:0];
  localparam logic               RECIP_HI = RECIP_WIDE[VALUE_W];

  // Architectural state.
  logic [RATE_W-1:0]  threshold;
  logic [VALUE_W-1:0] joined_value;
  logic               split_flag;
  logic [CNT_W-1:0]   abort_cnt;
  logic [CNT_W-1:0]   no_stock_cnt;
  logic [CNT_W-1:0]   commit_cnt;
  logic [CNT_W-1:0]   waiting_cnt;

  // Latched request.
  logic [OP_W-1:0]     op_r;
  logic [IDX_W-1:0]    tidx;
  logic [VALUE_W-1:0]  amount_r;
  logic [RATE_W-1:0]   rate_r;
  logic                report_nz;

  // Divider, sweep and accumulator.
  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quo;
  logic [REM_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] dcnt;
  logic [IDX_W-1:0]     idx;
  logic [VALUE_W-1:0]   sum;
  logic                 gpipe;

  // Chunk store port.
  logic               ram_we;
  logic [IDX_W-1:0]   ram_addr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [VALUE_W-1:0] ram_rdata;

  // Thread index folded into the chunk range.
  logic [IDX_W-1:0] thread_map [N_THREADS];

  for (genvar t = 0; t < N_THREADS; t++) begin : g_map
    assign thread_map[t] = IDX_W'(t % NUM_CHUNKS);
  end

  // Operand of the current request and its arithmetic.
  logic [VALUE_W-1:0] cur;
  logic [VALUE_W-1:0] sum_add;
  logic [VALUE_W-1:0] diff;
  logic               short_stock;
  logic [2*VALUE_W:0] prod_full;
  logic [VALUE_W-1:0] quo_calc;
  logic [VALUE_W-1:0] back_mul;
  logic [VALUE_W-1:0] rem_calc;

  assign cur         = split_flag ? ram_rdata : joined_value;
  assign sum_add     = cur + amount_r;
  assign diff        = cur - amount_r;
  assign short_stock = (cur < amount_r);

  // Split divide: the full reciprocal product, its quotient, then the remainder.
  assign prod_full = {1'b0, prod} +
                     (RECIP_HI ? {1'b0, joined_value, {VALUE_W{1'b0}}} : '0);
  assign quo_calc  = VALUE_W'(prod_full[2*VALUE_W:RECIP_SH]);
  assign back_mul  = quo * VALUE_W'(NUM_CHUNKS);
  assign rem_calc  = joined_value - back_mul;

  // Status to the controller.
  assign sts.is_transition = (op_r == OP_TRANS);
  assign sts.want_recon    = split_flag && report_nz;
  assign sts.want_split    = !split_flag && (rate_r > threshold);
  assign sts.div_last      = (dcnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign sts.idx_last      = (idx == IDX_W'(NUM_CHUNKS - 1));

  // Chunk store address, write enable and data.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = sum_add;
    priority if (cmd.load) begin
      ram_addr = thread_map[thread];
    end else if (cmd.fill || cmd.gather) begin
      ram_addr = idx;
    end else begin
      ram_addr = tidx;
    end
    if (cmd.exec && split_flag) begin
      if (op_r == OP_ADD) begin
        ram_we    = 1'b1;
        ram_wdata = sum_add;
      end else if (op_r == OP_SUB && !short_stock) begin
        ram_we    = 1'b1;
        ram_wdata = diff;
      end
    end
    if (cmd.fill) begin
      ram_we    = 1'b1;
      ram_wdata = (idx == '0) ? quo + VALUE_W'(rem) : quo;
    end
  end

  srctr_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (NUM_CHUNKS)
  ) u_chunks (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Request latch, divider, sweep and accumulator (no reset needed).
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= op;
      tidx      <= thread_map[thread];
      amount_r  <= amount;
      rate_r    <= abort_rate_permille;
      report_nz <= (waiting_count != '0) || (no_stock_count != '0);
    end
    if (cmd.exec) begin
      dcnt <= '0;
      idx  <= '0;
      sum  <= '0;
    end
    if (cmd.div_step) begin
      if (dcnt == DIV_CNT_W'(0)) begin
        prod <= (2*VALUE_W)'(joined_value) * (2*VALUE_W)'(RECIP_LO);
      end else if (dcnt == DIV_CNT_W'(1)) begin
        quo <= quo_calc;
      end else begin
        rem <= rem_calc[REM_W-1:0];
      end
      dcnt <= dcnt + DIV_CNT_W'(1);
    end
    if (cmd.fill || cmd.gather) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.gather && gpipe) begin
      sum <= sum + ram_rdata;
    end
  end

  // Control state, counters and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RESET;
      joined_value <= '0;
      split_flag   <= 1'b0;
      abort_cnt    <= '0;
      no_stock_cnt <= '0;
      commit_cnt   <= '0;
      waiting_cnt  <= '0;
      gpipe        <= 1'b0;
      done         <= 1'b0;
    end else begin
      gpipe <= cmd.gather;
      done  <= 1'b0;

      // Configuration writes.
      if (cfg_we) begin
        unique case (cfg_index)
          REG_THRESHOLD: threshold <= cfg_data[RATE_W-1:0];
          REG_INITIAL: begin
            joined_value <= cfg_data[VALUE_W-1:0];
            split_flag   <= 1'b0;
          end
          default: ;
        endcase
      end

      // Single-step requests.
      if (cmd.exec) begin
        read_value     <= '0;
        code           <= CODE_OK;
        split_now      <= split_flag;
        aborts_total   <= '0;
        no_stock_total <= '0;
        commits_total  <= '0;
        waiting_total  <= '0;
        done           <= 1'b1;
        unique case (op_r)
          OP_READ: begin
            if (split_flag) begin
              waiting_cnt <= sat_inc(waiting_cnt);
              abort_cnt   <= sat_inc(abort_cnt);
              code        <= CODE_RETRY;
            end else begin
              read_value <= joined_value;
              commit_cnt <= sat_inc(commit_cnt);
            end
          end
          OP_ADD: begin
            if (!split_flag) begin
              joined_value <= sum_add;
            end
            commit_cnt <= sat_inc(commit_cnt);
          end
          OP_SUB: begin
            if (short_stock) begin
              no_stock_cnt <= sat_inc(no_stock_cnt);
              abort_cnt    <= sat_inc(abort_cnt);
              code         <= CODE_NO_STOCK;
            end else begin
              if (!split_flag) begin
                joined_value <= diff;
              end
              commit_cnt <= sat_inc(commit_cnt);
            end
          end
          OP_TRANS: begin
            if (sts.want_recon || sts.want_split) begin
              done <= 1'b0;
            end else begin
              code <= CODE_NOT_TAKEN;
            end
          end
          OP_STATUS: begin
            aborts_total   <= abort_cnt;
            no_stock_total <= no_stock_cnt;
            commits_total  <= commit_cnt;
            waiting_total  <= waiting_cnt;
            abort_cnt      <= '0;
            no_stock_cnt   <= '0;
            commit_cnt     <= '0;
            waiting_cnt    <= '0;
          end
          default: ;
        endcase
      end

      // Split finishes with the last chunk write.
      if (cmd.fill && sts.idx_last) begin
        split_flag     <= 1'b1;
        read_value     <= '0;
        code           <= CODE_OK;
        split_now      <= 1'b1;
        aborts_total   <= '0;
        no_stock_total <= '0;
        commits_total  <= '0;
        waiting_total  <= '0;
        done           <= 1'b1;
      end

      // Reconcile folds in the last chunk and joins.
      if (cmd.gather_done) begin
        joined_value   <= sum + ram_rdata;
        split_flag     <= 1'b0;
        read_value     <= '0;
        code           <= CODE_OK;
        split_now      <= 1'b0;
        aborts_total   <= '0;
        no_stock_total <= '0;
        commits_total  <= '0;
        waiting_total  <= '0;
        done           <= 1'b1;
      end
    end
  end

endmodule

// File: tb/sv/split_reconcile_counter_top_test.sv
// Self-checking testbench for the split/reconcile stock counter top level.
module split_reconcile_counter_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import srctr_pkg::*;

  localparam int CLK_PERIOD        = 10;
  localparam int CHUNKS            = DEF_NUM_CHUNKS;
  localparam int RANDOM_PHASES     = 6;
  localparam int RANDOM_PER_PHASE  = 310;
  localparam int SPLIT_ROUNDS      = 20;
  localparam int STALL_LIMIT       = 2000;
  localparam int DRAIN_CYCLES      = 60;
  localparam int MAX_GAP           = 15;

  localparam logic [OP_W-1:0]    OP_UNUSED_LO = OP_STATUS + 3'd1;
  localparam logic [OP_W-1:0]    OP_UNUSED_HI = '1;
  localparam logic [RATE_W-1:0]  RATE_MAX     = '1;
  localparam logic [VALUE_W-1:0] VALUE_MAX    = '1;
  localparam logic [REPORT_W-1:0] REPORT_MAX  = '1;
  localparam logic [CNT_W-1:0]   CNT_FULL     = '1;

  // One result as it leaves the block.
  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic [CODE_W-1:0]  code;
    logic               split_now;
    logic [CNT_W-1:0]   aborts;
    logic [CNT_W-1:0]   no_stock;
    logic [CNT_W-1:0]   commits;
    logic [CNT_W-1:0]   waiting;
  } reply_t;

  // Tracks the counter state and the replies owed for accepted requests.
  class stock_tracker;
    logic [RATE_W-1:0]  threshold;
    logic [VALUE_W-1:0] joined;
    bit                 is_split;
    logic [VALUE_W-1:0] chunk [CHUNKS];
    logic [CNT_W-1:0]   aborts, no_stocks, commits, waits;
    reply_t             replies_due[$];
    int unsigned        fail_count, request_count, reply_count;
    int unsigned        split_count, join_count, retry_count, refused_subs, fetch_count;

    function new();
      threshold = THRESHOLD_RESET;
      joined = '0;
      is_split = 1'b0;
      foreach (chunk[i]) chunk[i] = '0;
      aborts = '0;
      no_stocks = '0;
      commits = '0;
      waits = '0;
    endfunction

    function logic [CNT_W-1:0] sat_bump(logic [CNT_W-1:0] c);
      return (c == CNT_FULL) ? c : c + 1'b1;
    endfunction

    function void set_target(int idx, logic [VALUE_W-1:0] v);
      if (is_split) chunk[idx] = v;
      else joined = v;
    endfunction

    function logic [VALUE_W-1:0] target(logic [THREAD_W-1:0] t);
      return is_split ? chunk[t % CHUNKS] : joined;
    endfunction

    function void load_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_THRESHOLD: threshold = data[RATE_W-1:0];
        REG_INITIAL: begin
          joined = data[VALUE_W-1:0];
          is_split = 1'b0;
        end
        default: ;
      endcase
    endfunction

    // Apply one accepted request to the state and queue the reply it owes.
    function void take_request(logic [OP_W-1:0] o, logic [THREAD_W-1:0] t,
                               logic [VALUE_W-1:0] a, logic [RATE_W-1:0] rt,
                               logic [REPORT_W-1:0] w, logic [REPORT_W-1:0] ns);
      reply_t r;
      logic [VALUE_W-1:0] cur, quot, sum;
      int idx;
      r = '0;
      idx = t % CHUNKS;
      cur = target(t);
      request_count++;
      case (o)
        OP_READ: begin
          if (is_split) begin
            waits = sat_bump(waits);
            aborts = sat_bump(aborts);
            r.code = CODE_RETRY;
            retry_count++;
          end else begin
            r.read_value = joined;
            commits = sat_bump(commits);
          end
        end
        OP_ADD: begin
          set_target(idx, cur + a);
          commits = sat_bump(commits);
        end
        OP_SUB: begin
          if (cur < a) begin
            no_stocks = sat_bump(no_stocks);
            aborts = sat_bump(aborts);
            r.code = CODE_NO_STOCK;
            refused_subs++;
          end else begin
            set_target(idx, cur - a);
            commits = sat_bump(commits);
          end
        end
        OP_TRANS: begin
          if (is_split && (w != '0 || ns != '0)) begin
            // Reconcile: fold every chunk back into the joined value.
            sum = '0;
            foreach (chunk[i]) sum += chunk[i];
            joined = sum;
            is_split = 1'b0;
            join_count++;
          end else if (!is_split && rt > threshold) begin
            // Split evenly; chunk 0 keeps the remainder.
            quot = joined / VALUE_W'(CHUNKS);
            foreach (chunk[i]) chunk[i] = quot;
            chunk[0] = quot + joined % VALUE_W'(CHUNKS);
            is_split = 1'b1;
            split_count++;
          end else begin
            r.code = CODE_NOT_TAKEN;
          end
        end
        OP_STATUS: begin
          r.aborts = aborts;
          r.no_stock = no_stocks;
          r.commits = commits;
          r.waiting = waits;
          aborts = '0;
          no_stocks = '0;
          commits = '0;
          waits = '0;
          fetch_count++;
        end
        default: ;
      endcase
      r.split_now = is_split;
      replies_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [VALUE_W-1:0] want,
                                logic [VALUE_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        fail_count++;
      end
    endfunction

    // Compare one observed result with the oldest reply owed.
    function void match_reply(reply_t got);
      reply_t want;
      reply_count++;
      if (replies_due.size() == 0) begin
        $display("%0t: result with no request outstanding: expected none, actual %h",
                 $time, got);
        fail_count++;
        return;
      end
      want = replies_due.pop_front();
      compare_field("read_value", want.read_value, got.read_value);
      compare_field("code", want.code, got.code);
      compare_field("split_now", want.split_now, got.split_now);
      compare_field("aborts_total", want.aborts, got.aborts);
      compare_field("no_stock_total", want.no_stock, got.no_stock);
      compare_field("commits_total", want.commits, got.commits);
      compare_field("waiting_total", want.waiting, got.waiting);
    endfunction

    function int pending();
      return replies_due.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic [OP_W-1:0]       op;
  logic [THREAD_W-1:0]   thread;
  logic [VALUE_W-1:0]    amount;
  logic [RATE_W-1:0]     abort_rate_permille;
  logic [REPORT_W-1:0]   waiting_count;
  logic [REPORT_W-1:0]   no_stock_count;
  logic                  done;
  logic [VALUE_W-1:0]    read_value;
  logic [CODE_W-1:0]     code;
  logic                  split_now;
  logic [CNT_W-1:0]      aborts_total;
  logic [CNT_W-1:0]      no_stock_total;
  logic [CNT_W-1:0]      commits_total;
  logic [CNT_W-1:0]      waiting_total;

  stock_tracker tracker;
  reply_t       seen;
  int unsigned  gap_max;
  int unsigned  stalled_cycles = 0;
  int unsigned  settings_count = 0;

  split_reconcile_counter_top #(.NUM_CHUNKS(CHUNKS)) uut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Check results first, then record any request taken at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        seen = '{read_value, code, split_now, aborts_total, no_stock_total,
                 commits_total, waiting_total};
        tracker.match_reply(seen);
      end
      if (start && !busy)
        tracker.take_request(op, thread, amount, abort_rate_permille, waiting_count,
                             no_stock_count);
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (done === 1'b1 || (start === 1'b1 && busy === 1'b0)) stalled_cycles <= 0;
    else stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
      $display("split_reconcile_counter_top regression: fail");
      $finish;
    end
  end

  // Present one request after a random gap and hold it until it is taken.
  task automatic send_request(input logic [OP_W-1:0] o, input logic [THREAD_W-1:0] t,
                              input logic [VALUE_W-1:0] a, input logic [RATE_W-1:0] rt,
                              input logic [REPORT_W-1:0] w, input logic [REPORT_W-1:0] ns);
    int unsigned gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    op = o;
    thread = t;
    amount = a;
    abort_rate_permille = rt;
    waiting_count = w;
    no_stock_count = ns;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop issuing and wait until every owed result has come back.
  task automatic settle();
    start = 1'b0;
    while (tracker.pending() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.load_register(idx, data);
  endtask

  // Random request, biased toward amounts and rates that hit the decision edges.
  task automatic random_request();
    logic [OP_W-1:0]     o;
    logic [THREAD_W-1:0] t;
    logic [VALUE_W-1:0]  a, cur;
    logic [RATE_W-1:0]   rt;
    logic [REPORT_W-1:0] w, ns;
    int unsigned         pick;
    pick = $urandom_range(0, 99);
    t = THREAD_W'($urandom);
    a = $urandom;
    rt = RATE_W'($urandom);
    w = REPORT_W'($urandom);
    ns = REPORT_W'($urandom);
    cur = tracker.target(t);
    if (pick < 18) o = OP_READ;
    else if (pick < 42) o = OP_ADD;
    else if (pick < 66) o = OP_SUB;
    else if (pick < 84) o = OP_TRANS;
    else if (pick < 92) o = OP_STATUS;
    else o = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    if (o == OP_ADD || o == OP_SUB) begin
      case ($urandom_range(0, 9))
        0, 1, 2: a = VALUE_W'($urandom_range(0, 255));
        3: a = cur;
        4: a = cur + 1'b1;
        5: a = cur - 1'b1;
        6: a = cur >> $urandom_range(1, 4);
        7: a = $urandom_range(0, 1) ? VALUE_MAX : '0;
        default: ;
      endcase
    end
    if (o == OP_TRANS) begin
      case ($urandom_range(0, 4))
        0, 1: rt = tracker.threshold + RATE_W'($urandom_range(0, 2)) - 1'b1;
        2: rt = $urandom_range(0, 1) ? RATE_MAX : '0;
        default: ;
      endcase
      if ($urandom_range(0, 1) == 0) w = '0;
      if ($urandom_range(0, 1) == 0) ns = '0;
      if ($urandom_range(0, 7) == 0) w = REPORT_MAX;
    end
    send_request(o, t, a, rt, w, ns);
  endtask

  initial begin
    tracker = new();
    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    op = '0;
    thread = '0;
    amount = '0;
    abort_rate_permille = '0;
    waiting_count = '0;
    no_stock_count = '0;
    gap_max = MAX_GAP;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Directed: wraparound, exact and failed subtracts, split and reconcile edges.
    settings_count++;
    send_request(OP_READ, 0, 0, 0, 0, 0);
    send_request(OP_SUB, 0, 1, 0, 0, 0);
    send_request(OP_ADD, 0, VALUE_MAX, 0, 0, 0);
    send_request(OP_ADD, 0, 5, 0, 0, 0);
    send_request(OP_SUB, 0, 4, 0, 0, 0);
    send_request(OP_ADD, 0, 15, 0, 0, 0);
    send_request(OP_READ, 7, VALUE_MAX, RATE_MAX, REPORT_MAX, REPORT_MAX);
    send_request(OP_TRANS, 0, 0, THRESHOLD_RESET, REPORT_MAX, 0);
    send_request(OP_TRANS, 0, 0, THRESHOLD_RESET + 1'b1, REPORT_MAX, 0);
    send_request(OP_READ, 0, 0, 0, 0, 0);
    send_request(OP_SUB, 3, 2, 0, 0, 0);
    send_request(OP_SUB, 0, 8, 0, 0, 0);
    send_request(OP_ADD, 7, VALUE_MAX, 0, 0, 0);
    send_request(OP_TRANS, 0, 0, RATE_MAX, 0, 0);
    send_request(OP_TRANS, 0, 0, 0, REPORT_MAX, 0);
    send_request(OP_TRANS, 0, 0, 10'd1000, 0, 0);
    send_request(OP_TRANS, 0, 0, 0, 0, REPORT_MAX);
    send_request(OP_STATUS, 0, 0, 0, 0, 0);
    send_request(OP_UNUSED_LO, 5, VALUE_MAX, RATE_MAX, REPORT_MAX, REPORT_MAX);
    send_request(OP_UNUSED_HI, 2, 1, 0, 0, 0);
    send_request(OP_STATUS, 0, 0, 0, 0, 0);
    send_request(OP_ADD, 0, 0, 0, 0, 0);
    send_request(OP_SUB, 0, 0, 0, 0, 0);
    send_request(OP_READ, 0, 0, 0, 0, 0);

    // Random phases, each under its own register setting and idling pattern.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p)
        0: write_reg(REG_THRESHOLD, '0);
        1: write_reg(REG_THRESHOLD, 1000);
        2: write_reg(REG_THRESHOLD, THRESHOLD_RESET);
        default: write_reg(REG_THRESHOLD, $urandom_range(0, 1000));
      endcase
      // Some phases keep the state left by the previous one.
      if (p < 3 || p == 4) begin
        case (p)
          0: write_reg(REG_INITIAL, VALUE_MAX);
          1: write_reg(REG_INITIAL, '0);
          2: write_reg(REG_INITIAL, $urandom_range(0, 100));
          default: write_reg(REG_INITIAL, $urandom);
        endcase
      end
      settings_count++;
      gap_max = (p % 2 == 0) ? MAX_GAP : 0;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) random_request();
    end

    // Back-to-back refused and committed requests on every chunk while split.
    settle();
    gap_max = 0;
    write_reg(REG_INITIAL, '0);
    settings_count++;
    send_request(OP_TRANS, 0, 0, RATE_MAX, 0, 0);
    send_request(OP_STATUS, 0, 0, 0, 0, 0);
    for (int i = 0; i < SPLIT_ROUNDS; i++) begin
      send_request(OP_READ, THREAD_W'(i), 0, 0, 0, 0);
      send_request(OP_SUB, THREAD_W'(i), 1, 0, 0, 0);
      send_request(OP_ADD, THREAD_W'(i), 0, 0, 0, 0);
    end
    send_request(OP_STATUS, 0, 0, 0, 0, 0);
    send_request(OP_STATUS, 0, 0, 0, 0, 0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests under %0d register settings: %0d splits, %0d reconciles,",
             tracker.request_count, settings_count, tracker.split_count, tracker.join_count);
    $display("%0d refused reads, %0d no-stock subtracts, %0d status fetches; %0d results.",
             tracker.retry_count, tracker.refused_subs, tracker.fetch_count,
             tracker.reply_count);
    if (tracker.fail_count == 0 && tracker.pending() == 0) begin
      $display("split_reconcile_counter_top regression: pass");
    end else begin
      $display("split_reconcile_counter_top regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/srctr_pkg.sv
src/srctr_ram.sv
src/srctr_ctrl.sv
src/srctr_dp.sv
src/split_reconcile_counter_top.sv
tb/sv/split_reconcile_counter_top_test.sv
